// ===== src/mpta_pkg.sv =====
// Shared types and constants for the MAC presence table with aging.
// Used by mpta_cell, mpta_head and mac_presence_table_aging.
`default_nettype none

package mpta_pkg;

  // Table geometry and field widths
  localparam int DEFAULT_DEPTH = 256;
  localparam int MAC_W         = 48;
  localparam int TTL_W         = 8;
  localparam int RSSI_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int INDEX_W       = 8;
  localparam int COUNT_W       = 8;
  localparam int EXPIRED_W     = 9;

  // TTL reload value after reset
  localparam logic [TTL_W-1:0] TTL_RELOAD_RESET = 8'd60;

  // Item opcodes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_REFRESH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEW     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WRAP    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TICK    = 2'd3;

  // One table entry as it travels along the ring
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TTL_W-1:0]  ttl;
    logic [RSSI_W-1:0] rssi;
    logic              active;
  } entry_t;

  // Transaction held for the length of one sweep
  typedef struct packed {
    logic              op;
    logic [MAC_W-1:0]  mac;
    logic [RSSI_W-1:0] rssi;
    logic [TTL_W-1:0]  ttl_reload;
  } req_t;

  // Position of the slot now at the head of the ring
  typedef struct packed {
    logic in_fill;   // slot is below the fill count
    logic at_fill;   // slot is the next one to append
    logic matched;   // an earlier slot already matched
  } head_pos_t;

  // What the head did to the passing slot
  typedef struct packed {
    logic hit;
    logic expire;
    logic append;
  } head_res_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

endpackage

`default_nettype wire

// ===== src/mpta_cell.sv =====
// One storage cell of the entry ring: holds one table entry.
// Depends on mpta_pkg for the entry type.
`default_nettype none

module mpta_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire mpta_pkg::entry_t d,
  output mpta_pkg::entry_t      q
);

  // Take the neighbor's entry on each ring step
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mpta_head.sv =====
// Update logic at the head of the entry ring: match, refresh, append, age.
// Depends on mpta_pkg for entry, request and result types.
`default_nettype none

module mpta_head (
  input  wire mpta_pkg::req_t      req,
  input  wire mpta_pkg::head_pos_t pos,
  input  wire mpta_pkg::entry_t    cur,
  output mpta_pkg::entry_t         upd,
  output mpta_pkg::head_res_t      res
);

  logic [mpta_pkg::TTL_W-1:0] ttl_dec;

  assign ttl_dec = cur.ttl - 1'b1;

  // Decide the fate of the slot passing the head
  always_comb begin
    upd = cur;
    res = '0;
    if (req.op == mpta_pkg::OP_TICK) begin
      // Age active filled slots, drop those reaching zero
      if (pos.in_fill && cur.active) begin
        upd.ttl = ttl_dec;
        if (ttl_dec == '0) begin
          upd.active = 1'b0;
          res.expire = 1'b1;
        end
      end
    end else begin
      if (pos.in_fill && !pos.matched && (cur.mac == req.mac)) begin
        // Refresh the first matching slot
        upd.ttl    = req.ttl_reload;
        upd.rssi   = req.rssi;
        upd.active = 1'b1;
        res.hit    = 1'b1;
      end else if (pos.at_fill && !pos.matched) begin
        // No match among filled slots: append here
        upd.mac    = req.mac;
        upd.ttl    = req.ttl_reload;
        upd.rssi   = req.rssi;
        upd.active = 1'b1;
        res.append = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mac_presence_table_aging.sv =====
// Top level of the MAC presence table with aging: entry ring and sequencer.
// Depends on mpta_pkg, mpta_cell and mpta_head.
`default_nettype none

// The table lives in a ring of TABLE_DEPTH cells that rotates one slot per
// cycle past a single update head while a sweep runs; the last step of a sweep
// waits until the output register is free. Every transaction, frame or tick,
// makes one full turn of the ring before its result is loaded into the output
// register. The next transaction is taken after the result is loaded, once the
// sequencer is back in idle. One transaction is in work at a time; a result
// waiting in the output register does not stop the next transaction from being
// accepted. Nothing is accepted while reset is high. No clearing pass is needed
// after reset.
module mac_presence_table_aging #(
  parameter int TABLE_DEPTH = mpta_pkg::DEFAULT_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic [mpta_pkg::MAC_W-1:0]          source_mac,
  input  wire logic signed [mpta_pkg::RSSI_W-1:0]  signal_strength,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mpta_pkg::STATUS_W-1:0]            status,
  output logic [mpta_pkg::INDEX_W-1:0]             entry_index,
  output logic [mpta_pkg::COUNT_W-1:0]             entry_count,
  output logic [mpta_pkg::EXPIRED_W-1:0]           expired_count,
  // configuration write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mpta_pkg::TTL_W-1:0]          cfg_data
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int EW  = $clog2(TABLE_DEPTH + 1);
  localparam int OW  = (IW > mpta_pkg::INDEX_W) ? IW : mpta_pkg::INDEX_W;
  localparam int XW  = (EW > mpta_pkg::EXPIRED_W) ? EW : mpta_pkg::EXPIRED_W;
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  mpta_pkg::state_t    state, state_next;
  mpta_pkg::req_t      req;
  mpta_pkg::head_pos_t pos;
  mpta_pkg::head_res_t res;
  mpta_pkg::entry_t    head_upd;
  mpta_pkg::entry_t    cell_q [TABLE_DEPTH];
  mpta_pkg::entry_t    cell_d [TABLE_DEPTH];

  logic [mpta_pkg::TTL_W-1:0] ttl_reload;
  logic [IW-1:0]              step;
  logic [IW-1:0]              fill;
  logic [IW-1:0]              fill_next;
  logic [IW-1:0]              hit_idx;
  logic [IW-1:0]              res_idx;
  logic [EW-1:0]              expired;
  logic [EW-1:0]              expired_total;
  logic                       matched;
  logic                       out_free;
  logic                       at_last;
  logic                       sweep_en;
  logic                       finish;
  logic                       accept;
  logic                       hit_any;
  logic [OW-1:0]              idx_wide;
  logic [OW-1:0]              cnt_wide;
  logic [XW-1:0]              exp_wide;

  // Configuration register, held off during reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_reload <= mpta_pkg::TTL_RELOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ttl_reload <= cfg_data;
    end
  end

  // Entry ring: each cell takes its upper neighbor, the top takes the head
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_ring
    if (j == TABLE_DEPTH - 1) begin : g_top
      assign cell_d[j] = head_upd;
    end else begin : g_mid
      assign cell_d[j] = cell_q[j+1];
    end
    mpta_cell u_cell (
      .clk   (clk),
      .shift (sweep_en),
      .d     (cell_d[j]),
      .q     (cell_q[j])
    );
  end

  // Head position of the slot now at cell zero
  always_comb begin
    pos.in_fill = (step < fill);
    pos.at_fill = (step == fill);
    pos.matched = matched;
  end

  mpta_head u_head (
    .req (req),
    .pos (pos),
    .cur (cell_q[0]),
    .upd (head_upd),
    .res (res)
  );

  // Handshake and sweep control
  assign out_free = !out_valid || out_ready;
  assign at_last  = (step == LAST);
  assign accept   = in_valid && in_ready;
  assign finish   = sweep_en && at_last;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mpta_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mpta_pkg::ST_SWEEP;
        end
      end
      mpta_pkg::ST_SWEEP: begin
        if (at_last && out_free) begin
          state_next = mpta_pkg::ST_IDLE;
        end
      end
      default: state_next = mpta_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    sweep_en = 1'b0;
    case (state)
      mpta_pkg::ST_IDLE: begin
        in_ready = !rst;
      end
      mpta_pkg::ST_SWEEP: begin
        sweep_en = !at_last || out_free;
      end
      default: begin
        in_ready = 1'b0;
        sweep_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the transaction at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      req.op         <= op;
      req.mac        <= source_mac;
      req.rssi       <= signal_strength;
      req.ttl_reload <= ttl_reload;
    end
  end

  // Step counter, first-match tracking and expiry count
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      matched <= 1'b0;
      expired <= '0;
    end else if (accept) begin
      step    <= '0;
      matched <= 1'b0;
      expired <= '0;
    end else if (sweep_en) begin
      step <= step + 1'b1;
      if (res.hit) begin
        matched <= 1'b1;
      end
      if (res.expire) begin
        expired <= expired + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_en && res.hit) begin
      hit_idx <= step;
    end
  end

  // Result fields at the end of the sweep
  assign hit_any       = matched || res.hit;
  assign res_idx       = res.hit ? step : hit_idx;
  assign fill_next     = (fill == LAST) ? '0 : fill + 1'b1;
  assign expired_total = expired + EW'(res.expire);

  always_comb begin
    if (req.op == mpta_pkg::OP_TICK) begin
      idx_wide = '0;
      cnt_wide = OW'(fill);
      exp_wide = XW'(expired_total);
    end else if (hit_any) begin
      idx_wide = OW'(res_idx);
      cnt_wide = OW'(fill);
      exp_wide = '0;
    end else begin
      idx_wide = OW'(fill);
      cnt_wide = OW'(fill_next);
      exp_wide = '0;
    end
  end

  // Fill count advances on an append
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (finish && (req.op == mpta_pkg::OP_FRAME) && !hit_any) begin
      fill <= fill_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (req.op == mpta_pkg::OP_TICK) begin
        status <= mpta_pkg::STATUS_TICK;
      end else if (hit_any) begin
        status <= mpta_pkg::STATUS_REFRESH;
      end else if (fill == LAST) begin
        status <= mpta_pkg::STATUS_WRAP;
      end else begin
        status <= mpta_pkg::STATUS_NEW;
      end
      entry_index   <= idx_wide[mpta_pkg::INDEX_W-1:0];
      entry_count   <= cnt_wide[mpta_pkg::COUNT_W-1:0];
      expired_count <= exp_wide[mpta_pkg::EXPIRED_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== test/mac_presence_table_aging_tb.sv =====
// Self-checking testbench for mac_presence_table_aging: frames, ticks, TTL writes.
// Depends on mpta_pkg and the mac_presence_table_aging top level in src.
`default_nettype none

module mac_presence_table_aging_tb;

  localparam int TABLE_DEPTH = mpta_pkg::DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [mpta_pkg::STATUS_W-1:0]  status;
    logic [mpta_pkg::INDEX_W-1:0]   index;
    logic [mpta_pkg::COUNT_W-1:0]   count;
    logic [mpta_pkg::EXPIRED_W-1:0] expired;
  } table_reply_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               op = mpta_pkg::OP_FRAME;
  logic [mpta_pkg::MAC_W-1:0]         source_mac = '0;
  logic signed [mpta_pkg::RSSI_W-1:0] signal_strength = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [mpta_pkg::STATUS_W-1:0]      status;
  logic [mpta_pkg::INDEX_W-1:0]       entry_index;
  logic [mpta_pkg::COUNT_W-1:0]       entry_count;
  logic [mpta_pkg::EXPIRED_W-1:0]     expired_count;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [mpta_pkg::TTL_W-1:0]         cfg_data = '0;

  // Shadow copy of the presence table and its TTL register
  logic [mpta_pkg::MAC_W-1:0]  slot_mac [TABLE_DEPTH];
  logic [mpta_pkg::TTL_W-1:0]  slot_ttl [TABLE_DEPTH];
  logic [mpta_pkg::RSSI_W-1:0] slot_rssi [TABLE_DEPTH];
  bit                          slot_active [TABLE_DEPTH];
  int                          fill_level = 0;
  int                          slots_used = 0;
  int                          wraps_seen = 0;
  logic [mpta_pkg::TTL_W-1:0]  ttl_reload_now = mpta_pkg::TTL_RELOAD_RESET;

  table_reply_t awaited_replies [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           steady_flow = 1'b0;
  int           stall_left = 0;

  mac_presence_table_aging #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .source_mac     (source_mac),
    .signal_strength(signal_strength),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_index    (entry_index),
    .entry_count    (entry_count),
    .expired_count  (expired_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(string what);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Idle length for either side: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Age, refresh or append in the shadow table and queue the reply it implies
  function automatic void apply_to_table(logic op_in, logic [mpta_pkg::MAC_W-1:0] mac,
                                         logic [mpta_pkg::RSSI_W-1:0] rssi);
    table_reply_t reply;
    int hit;
    int expired;
    int slot;
    hit = -1;
    expired = 0;
    if (op_in == mpta_pkg::OP_TICK) begin
      for (int i = 0; i < fill_level; i++) begin
        if (slot_active[i]) begin
          slot_ttl[i] = slot_ttl[i] - 1'b1;
          if (slot_ttl[i] == '0) begin
            slot_active[i] = 1'b0;
            expired++;
          end
        end
      end
      reply = '{mpta_pkg::STATUS_TICK, '0, mpta_pkg::COUNT_W'(fill_level),
                mpta_pkg::EXPIRED_W'(expired)};
    end else begin
      for (int i = 0; i < fill_level && hit < 0; i++)
        if (slot_mac[i] == mac)
          hit = i;
      if (hit >= 0) begin
        slot_ttl[hit] = ttl_reload_now;
        slot_rssi[hit] = rssi;
        slot_active[hit] = 1'b1;
        reply = '{mpta_pkg::STATUS_REFRESH, mpta_pkg::INDEX_W'(hit),
                  mpta_pkg::COUNT_W'(fill_level), '0};
      end else begin
        slot = fill_level;
        slot_mac[slot] = mac;
        slot_ttl[slot] = ttl_reload_now;
        slot_rssi[slot] = rssi;
        slot_active[slot] = 1'b1;
        if (slot + 1 > slots_used)
          slots_used = slot + 1;
        fill_level = slot + 1;
        reply.status = mpta_pkg::STATUS_NEW;
        if (fill_level >= TABLE_DEPTH) begin
          fill_level = 0;
          wraps_seen++;
          reply.status = mpta_pkg::STATUS_WRAP;
        end
        reply.index = mpta_pkg::INDEX_W'(slot);
        reply.count = mpta_pkg::COUNT_W'(fill_level);
        reply.expired = '0;
      end
    end
    awaited_replies.push_back(reply);
  endfunction

  // Offer one transaction and predict its reply once it is taken
  task automatic send_item(logic op_in, logic [mpta_pkg::MAC_W-1:0] mac,
                           logic [mpta_pkg::RSSI_W-1:0] rssi);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = op_in;
    source_mac = mac;
    signal_strength = rssi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_table(op_in, mac, rssi);
  endtask

  task automatic stop_items();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Write the TTL reload only once every reply is back
  task automatic write_ttl(logic [mpta_pkg::TTL_W-1:0] value);
    stop_items();
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ttl_reload_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Tick, fresh address or an address already placed in the table
  task automatic random_item(int fresh_pct, int tick_pct);
    int r;
    logic [mpta_pkg::MAC_W-1:0] mac;
    logic [mpta_pkg::RSSI_W-1:0] rssi;
    r = $urandom_range(0, 99);
    mac[47:32] = 16'($urandom);
    mac[31:0] = $urandom;
    rssi = 8'($urandom);
    if ($urandom_range(0, 99) < 3)
      steady_flow = !steady_flow;
    if (r < tick_pct)
      send_item(mpta_pkg::OP_TICK, mac, rssi);
    else if (r < tick_pct + fresh_pct || slots_used == 0)
      send_item(mpta_pkg::OP_FRAME, mac, rssi);
    else
      send_item(mpta_pkg::OP_FRAME, slot_mac[$urandom_range(0, slots_used - 1)], rssi);
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report($sformatf("unexpected result status %0d index %0d", status, entry_index));
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.status || entry_index !== want.index ||
            entry_count !== want.count || expired_count !== want.expired)
          report($sformatf("got status %0d index %0d count %0d expired %0d, want %0d %0d %0d %0d",
                           status, entry_index, entry_count, expired_count,
                           want.status, want.index, want.count, want.expired));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      stall_left = idle_len();
    end
  end

  // Append, refresh and tick with the reset TTL; address and strength extremes
  task automatic test_first_entries();
    send_item(mpta_pkg::OP_FRAME, '0, 8'h80);
    send_item(mpta_pkg::OP_FRAME, '1, 8'h7f);
    send_item(mpta_pkg::OP_FRAME, '0, 8'h00);
    send_item(mpta_pkg::OP_TICK, '1, 8'hff);
    send_item(mpta_pkg::OP_FRAME, 48'h0123_4567_89ab, 8'hc4);
    send_item(mpta_pkg::OP_FRAME, 48'hfedc_ba98_7654, 8'h3b);
  endtask

  // Shortest TTL: entries expire on the next tick and come back when seen
  task automatic test_expiry();
    write_ttl(8'd1);
    send_item(mpta_pkg::OP_FRAME, '0, 8'hd0);
    send_item(mpta_pkg::OP_FRAME, 48'h0123_4567_89ab, 8'hd1);
    send_item(mpta_pkg::OP_TICK, '0, '0);
    send_item(mpta_pkg::OP_TICK, '0, '0);
    write_ttl(8'd2);
    send_item(mpta_pkg::OP_FRAME, '0, 8'hd2);
    send_item(mpta_pkg::OP_TICK, '0, '0);
    send_item(mpta_pkg::OP_TICK, '0, '0);
  endtask

  // Zero reload: the tick after a refresh wraps the TTL and keeps it active
  task automatic test_zero_reload();
    write_ttl(8'd0);
    send_item(mpta_pkg::OP_FRAME, '1, 8'h01);
    send_item(mpta_pkg::OP_FRAME, 48'h5555_aaaa_5555, 8'h81);
    send_item(mpta_pkg::OP_TICK, '0, '0);
    write_ttl(8'd255);
    send_item(mpta_pkg::OP_FRAME, '0, 8'h7e);
    send_item(mpta_pkg::OP_TICK, '0, '0);
  endtask

  // Fill past the depth, then mix addresses from above and below the fill count
  task automatic test_table_wrap();
    write_ttl(8'($urandom_range(2, 6)));
    while (wraps_seen == 0)
      random_item(85, 7);
    repeat (30) random_item(30, 25);
  endtask

  // Mixed traffic over several TTL settings
  task automatic test_random_traffic();
    write_ttl(8'd255);
    repeat (25) random_item(40, 20);
    write_ttl(8'd1);
    repeat (25) random_item(40, 30);
    write_ttl(8'($urandom_range(1, 255)));
    repeat (25) random_item(40, 20);
    write_ttl(8'($urandom_range(2, 10)));
    repeat (25) random_item(30, 35);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_first_entries();
    test_expiry();
    test_zero_reload();
    test_table_wrap();
    test_random_traffic();
    stop_items();
    wait_drained();
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
